/* hw/rtl/dep_pkg.sv */
// types, codes and the key ordering function for the double-ended priority queue
// no dependencies; used by the slot array, the readout, the checker and the top level
package dep_pkg;

  localparam int unsigned ScoreW = 32;
  localparam int unsigned IdentW = 31;
  localparam int unsigned CountOutW = 7;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_MIN = 2'd1,
    OP_DEL_MAX = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic [IdentW-1:0]        ident;
  } entry_t;

  typedef struct packed {
    op_e    op;
    entry_t entry;
  } req_t;

  // strict order: signed score first, then ident
  function automatic logic key_less(entry_t a, entry_t b);
    logic lt;
    if (a.score != b.score) begin
      lt = (a.score < b.score);
    end else begin
      lt = (a.ident < b.ident);
    end
    return lt;
  endfunction

endpackage

/* hw/rtl/double_ended_priority_queue.sv */
// top level of the double-ended priority queue: input register, slot array, readout
// depends on dep_pkg, dep_slot_array and dep_readout
//
// usage
// - input channel in_valid_i/in_ready_o carries one operation word: opcode_i,
//   score_i, ident_i (insert, delete min, delete max, query)
// - output channel out_valid_o/out_ready_i carries one result word per
//   operation: min and max entries, entry_count_o, is_empty_o, status_o
// - an accepted word passes the input register, the slot update, then the readout
//   register before its result is valid
// - throughput: one operation per cycle unless out_ready_i stalls the pipe;
//   all CAPACITY slots update at once, with a compare per slot and a one-slot shift
// - the output register holds its word while out_ready_i is low; the whole
//   pipe then freezes and in_ready_o drops once the input register is full
// - reset empties the set (count cleared); slot contents above the count are
//   never read, so no clearing pass is needed
// - min and max fields read zero while the set is empty
module double_ended_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic signed [31:0]  score_i,
  input  logic [30:0]         ident_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  min_score_o,
  output logic [30:0]         min_ident_o,
  output logic signed [31:0]  max_score_o,
  output logic [30:0]         max_ident_o,
  output logic [6:0]          entry_count_o,
  output logic                is_empty_o,
  output logic [1:0]          status_o
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  dep_pkg::req_t     req_q;
  logic              in_valid_q;
  logic              s2_valid_q;
  dep_pkg::status_e  s2_status_q;
  logic              out_valid_q;
  dep_pkg::entry_t   min_q, max_q;
  logic [6:0]        count_out_q;
  logic              empty_q;
  dep_pkg::status_e  status_q;

  dep_pkg::entry_t   slots [CAPACITY];
  logic [CountW-1:0] count;
  dep_pkg::status_e  status;
  dep_pkg::entry_t   min_e, max_e;
  logic              advance;
  logic              apply;

  assign advance    = !out_valid_q || out_ready_i;
  assign apply      = advance && in_valid_q;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.op          <= dep_pkg::op_e'(opcode_i);
      req_q.entry.score <= score_i;
      req_q.entry.ident <= ident_i;
    end
  end

  dep_slot_array #(
    .CAPACITY(CAPACITY)
  ) u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .apply_i  (apply),
    .req_i    (req_q),
    .slots_o  (slots),
    .count_o  (count),
    .status_o (status)
  );

  dep_readout #(
    .CAPACITY(CAPACITY)
  ) u_readout (
    .slots_i (slots),
    .count_i (count),
    .min_o   (min_e),
    .max_o   (max_e)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q  <= in_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_status_q <= status;
      status_q    <= s2_status_q;
      min_q       <= min_e;
      max_q       <= max_e;
      count_out_q <= 7'(count);
      empty_q     <= (count == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign min_score_o   = min_q.score;
  assign min_ident_o   = min_q.ident;
  assign max_score_o   = max_q.score;
  assign max_ident_o   = max_q.ident;
  assign entry_count_o = count_out_q;
  assign is_empty_o    = empty_q;
  assign status_o      = status_q;

endmodule

/* hw/rtl/dep_slot_array.sv */
// sorted row of entry slots with parallel compare-and-shift and the fill count
// depends on dep_pkg
module dep_slot_array #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CountW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  apply_i,
  input  dep_pkg::req_t         req_i,
  output dep_pkg::entry_t       slots_o [CAPACITY],
  output logic [CountW-1:0]     count_o,
  output dep_pkg::status_e      status_o
);

  dep_pkg::entry_t slot_q [CAPACITY];
  dep_pkg::entry_t slot_d [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [CountW-1:0] count_q, count_d;
  logic dup, full;
  logic do_ins, do_del_min;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    logic held;
    assign held = (CountW'(i) < count_q);
    assign lt[i] = held && dep_pkg::key_less(slot_q[i], req_i.entry);
    assign eq[i] = held && (slot_q[i] == req_i.entry);
  end

  assign dup  = |eq;
  assign full = (count_q == CountW'(CAPACITY));

  always_comb begin
    status_o   = dep_pkg::ST_DONE;
    count_d    = count_q;
    do_ins     = 1'b0;
    do_del_min = 1'b0;
    case (req_i.op)
      dep_pkg::OP_INSERT: begin
        if (dup) begin
          status_o = dep_pkg::ST_DUPLICATE;
        end else if (full) begin
          status_o = dep_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + CountW'(1);
        end
      end
      dep_pkg::OP_DEL_MIN: begin
        if (count_q == '0) begin
          status_o = dep_pkg::ST_EMPTY;
        end else begin
          do_del_min = 1'b1;
          count_d    = count_q - CountW'(1);
        end
      end
      dep_pkg::OP_DEL_MAX: begin
        if (count_q == '0) begin
          status_o = dep_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - CountW'(1);
        end
      end
      default: begin
        status_o = dep_pkg::ST_DONE;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    dep_pkg::entry_t upper;
    dep_pkg::entry_t lower;
    logic lower_lt;
    if (i == 0) begin : g_first
      assign lower    = req_i.entry;
      assign lower_lt = 1'b1;
    end else begin : g_rest
      assign lower    = slot_q[i-1];
      assign lower_lt = lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = slot_q[i];
    end else begin : g_inner
      assign upper = slot_q[i+1];
    end

    always_comb begin
      slot_d[i] = slot_q[i];
      if (do_ins) begin
        if (lt[i]) begin
          slot_d[i] = slot_q[i];
        end else if (lower_lt) begin
          slot_d[i] = req_i.entry;
        end else begin
          slot_d[i] = lower;
        end
      end else if (do_del_min) begin
        slot_d[i] = upper;
      end
    end

    always_ff @(posedge clk_i) begin
      if (apply_i) begin
        slot_q[i] <= slot_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (apply_i) begin
      count_q <= count_d;
    end
  end

  assign slots_o = slot_q;
  assign count_o = count_q;

endmodule

/* hw/rtl/dep_readout.sv */
// picks the smallest and largest held entries out of the slot row
// depends on dep_pkg
module dep_readout #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CountW = $clog2(CAPACITY + 1)
) (
  input  dep_pkg::entry_t   slots_i [CAPACITY],
  input  logic [CountW-1:0] count_i,
  output dep_pkg::entry_t   min_o,
  output dep_pkg::entry_t   max_o
);

  logic [CountW-1:0] last;
  logic [CAPACITY-1:0] sel;

  assign last = count_i - CountW'(1);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_sel
    assign sel[i] = (CountW'(i) == last);
  end

  always_comb begin
    max_o = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      max_o = max_o | (sel[i] ? slots_i[i] : '0);
    end
    if (count_i == '0) begin
      max_o = '0;
    end
  end

  assign min_o = (count_i == '0) ? '0 : slots_i[0];

endmodule

/* hw/rtl/dep_checker.sv */
// port-level checks for the double-ended priority queue, bound to the top level
// depends on dep_pkg and double_ended_priority_queue
module dep_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] min_score_o,
  input logic [30:0]        min_ident_o,
  input logic signed [31:0] max_score_o,
  input logic [30:0]        max_ident_o,
  input logic [6:0]         entry_count_o,
  input logic               is_empty_o,
  input logic [1:0]         status_o
);

  localparam logic [6:0] FullCount = 7'(CAPACITY);

  // stalled result word holds: status, count, min score and max ident stay stable
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(entry_count_o) && $stable(min_score_o) && $stable(max_ident_o))
    else $error("result word changed while stalled");

  // empty set reports zero min and max
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> min_score_o == '0 && min_ident_o == '0
      && max_score_o == '0 && max_ident_o == '0)
    else $error("nonzero min or max on empty set");

  // delete on empty leaves the set empty
  a_del_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dep_pkg::ST_EMPTY |-> is_empty_o)
    else $error("delete-on-empty status with entries held");

  // full status only when the set is full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == dep_pkg::ST_FULL |-> entry_count_o == FullCount
      && !is_empty_o)
    else $error("full status with set not full");

  // single entry: min and max are the same entry
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_count_o == 7'd1 && CAPACITY < 128
      |-> min_score_o == max_score_o && min_ident_o == max_ident_o)
    else $error("min and max differ with one entry held");

endmodule

bind double_ended_priority_queue dep_checker #(.CAPACITY(CAPACITY)) u_dep_checker (.*);
